FILE: src/mss_pkg.sv
`timescale 1ns / 1ps

package mss_pkg;

  localparam int MAX_CHANNELS_DEF = 16;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_EDIT = 2'd2;

  localparam logic [2:0] KIND_DUE  = 3'd0;
  localparam logic [2:0] KIND_WAKE = 3'd1;
  localparam logic [2:0] KIND_ADD  = 3'd2;
  localparam logic [2:0] KIND_EDIT = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] now_us;
    logic [3:0]  channel;
    logic [31:0] period_us;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel_index;
    logic [31:0] delay_us;
    logic        suspend;
    logic        overrun;
    logic        last;
  } result_t;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic sweep;
    logic rescan;
    logic rd_fast;
    logic sum;
    logic wake;
    logic add_wr;
    logic edit_wr;
    logic take_best;
    logic err;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       bad_ch;
    logic       sweep_done;
    logic       need_rescan;
  } status_t;

endpackage

FILE: src/mss_ctrl.sv
`timescale 1ns / 1ps

module mss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mss_pkg::status_t status,
  output mss_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_SCAN    = 11'b000_0000_0010,
    S_FAST    = 11'b000_0000_0100,
    S_SUM     = 11'b000_0000_1000,
    S_WAKE    = 11'b000_0001_0000,
    S_ADD_RD  = 11'b000_0010_0000,
    S_ADD_WR  = 11'b000_0100_0000,
    S_EDIT_RD = 11'b000_1000_0000,
    S_EDIT_WR = 11'b001_0000_0000,
    S_RESCAN  = 11'b010_0000_0000,
    S_ERR     = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (status.mode == mss_pkg::MODE_TICK) begin
            state_next = S_SCAN;
          end else if (status.mode == mss_pkg::MODE_ADD) begin
            state_next = status.full ? S_ERR : S_ADD_RD;
          end else if (status.mode == mss_pkg::MODE_EDIT) begin
            state_next = status.bad_ch ? S_ERR : S_EDIT_RD;
          end else begin
            state_next = S_ERR;
          end
        end
      end
      S_SCAN: begin
        cmd.sweep = 1'b1;
        if (status.sweep_done) begin
          state_next = S_FAST;
        end
      end
      S_FAST: begin
        cmd.rd_fast = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_WAKE;
      end
      S_WAKE: begin
        cmd.wake   = 1'b1;
        state_next = S_IDLE;
      end
      S_ADD_RD: begin
        cmd.rd_fast = 1'b1;
        state_next  = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_EDIT_RD: begin
        cmd.rd_fast = 1'b1;
        state_next  = S_EDIT_WR;
      end
      S_EDIT_WR: begin
        cmd.edit_wr = 1'b1;
        cmd.idx_clr = 1'b1;
        state_next  = status.need_rescan ? S_RESCAN : S_IDLE;
      end
      S_RESCAN: begin
        cmd.sweep  = 1'b1;
        cmd.rescan = 1'b1;
        if (status.sweep_done) begin
          cmd.take_best = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_ERR: begin
        cmd.err    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not leave idle");

endmodule

FILE: src/mss_datapath.sv
`timescale 1ns / 1ps

module mss_datapath #(
  parameter int MAX_CHANNELS = mss_pkg::MAX_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mss_pkg::item_t    item,
  input  mss_pkg::cmd_t     cmd,
  output mss_pkg::status_t  status,
  output mss_pkg::result_t  result,
  output logic              result_strobe
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int IW = (CW > 4) ? CW : 4;

  logic [31:0] period_mem [MAX_CHANNELS];
  logic [63:0] time_mem   [MAX_CHANNELS];

  mss_pkg::item_t   item_q;
  mss_pkg::result_t res_next;
  logic [CW-1:0] count_q;
  logic [AW-1:0] fastest_q;
  logic [CW-1:0] idx_q;
  logic          chk_v_q;
  logic [AW-1:0] chk_addr_q;
  logic [31:0]   per_rd;
  logic [63:0]   time_rd;
  logic [AW-1:0] best_q;
  logic [31:0]   best_per_q;
  logic [63:0]   due_q;
  logic          never_q;

  logic          more;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] ch_addr;
  logic [AW-1:0] cnt_addr;
  logic [31:0]   elapsed;
  logic          tick_due;
  logic          faster;
  logic [63:0]   diff;
  logic          emit;

  assign more     = (idx_q < count_q);
  assign rd_addr  = cmd.rd_fast ? fastest_q : idx_q[AW-1:0];
  assign ch_addr  = AW'(item_q.channel);
  assign cnt_addr = count_q[AW-1:0];
  assign elapsed  = item_q.now_us[31:0] - time_rd[31:0];
  assign tick_due = cmd.sweep && !cmd.rescan && chk_v_q && (elapsed >= per_rd);
  assign faster   = (item_q.period_us < per_rd);
  assign diff     = due_q - item_q.now_us;
  assign emit     = tick_due || cmd.wake || cmd.add_wr || cmd.edit_wr || cmd.err;

  assign status.mode        = item.mode;
  assign status.full        = (count_q >= CW'(MAX_CHANNELS));
  assign status.bad_ch      = (IW'(item.channel) >= IW'(count_q));
  assign status.sweep_done  = !more && !chk_v_q;
  assign status.need_rescan = !faster && (ch_addr == fastest_q);

  always_comb begin
    res_next = '0;
    if (tick_due) begin
      res_next.kind          = mss_pkg::KIND_DUE;
      res_next.channel_index = 4'(chk_addr_q);
    end else if (cmd.wake) begin
      res_next.kind    = mss_pkg::KIND_WAKE;
      res_next.last    = 1'b1;
      res_next.suspend = (count_q == '0) || never_q;
      if (!res_next.suspend) begin
        if (due_q > item_q.now_us) begin
          res_next.delay_us = (diff[63:32] != '0) ? '1 : diff[31:0];
        end else begin
          res_next.overrun = 1'b1;
        end
      end
    end else if (cmd.add_wr) begin
      res_next.kind          = mss_pkg::KIND_ADD;
      res_next.channel_index = 4'(count_q);
      res_next.last          = 1'b1;
    end else if (cmd.edit_wr) begin
      res_next.kind          = mss_pkg::KIND_EDIT;
      res_next.channel_index = item_q.channel;
      res_next.last          = 1'b1;
    end else if (cmd.err) begin
      res_next.kind = mss_pkg::KIND_ERR;
      res_next.last = 1'b1;
    end
  end

  // channel table
  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      period_mem[cnt_addr] <= item_q.period_us;
      time_mem[cnt_addr]   <= '0;
    end else if (cmd.edit_wr) begin
      period_mem[ch_addr] <= item_q.period_us;
    end else if (tick_due) begin
      time_mem[chk_addr_q] <= item_q.now_us;
    end
  end

  always_ff @(posedge clk) begin
    per_rd  <= period_mem[rd_addr];
    time_rd <= time_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q       <= '0;
      fastest_q     <= '0;
      idx_q         <= '0;
      chk_v_q       <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
      chk_v_q       <= cmd.sweep && more;
      if (cmd.load || cmd.idx_clr) begin
        idx_q <= '0;
      end else if (cmd.sweep && more) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd.add_wr) begin
        count_q <= count_q + CW'(1);
        if (count_q == '0) begin
          fastest_q <= '0;
        end else if (faster) begin
          fastest_q <= cnt_addr;
        end
      end else if (cmd.edit_wr) begin
        if (faster) begin
          fastest_q <= ch_addr;
        end
      end else if (cmd.take_best) begin
        fastest_q <= best_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    chk_addr_q <= rd_addr;
    if (emit) begin
      result <= res_next;
    end
    if (cmd.sum) begin
      due_q   <= time_rd + 64'(per_rd);
      never_q <= &per_rd;
    end
    // first minimum: strict compare keeps the earliest index
    if (cmd.sweep && cmd.rescan && chk_v_q) begin
      if ((chk_addr_q == '0) || (per_rd < best_per_q)) begin
        best_q     <= chk_addr_q;
        best_per_q <= per_rd;
      end
    end
  end

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    cmd.add_wr |=> (count_q == $past(count_q) + CW'(1)))
    else $error("channel count did not advance on add");

  a_fast_range: assert property (@(posedge clk) disable iff (rst)
    (count_q != '0) |-> (CW'(fastest_q) < count_q))
    else $error("fastest index outside used channels");

  a_chk_origin: assert property (@(posedge clk) disable iff (rst)
    chk_v_q |-> $past(cmd.sweep))
    else $error("check slot valid without a preceding sweep read");

endmodule

FILE: src/multichannel_sample_scheduler_unit.sv
`timescale 1ns / 1ps

// channel  | ports                            | handshake
// ---------+----------------------------------+------------------------------
// item in  | start, busy, item                | taken when start && !busy
// result   | result_strobe, result            | one cycle per result, no stall
//
// Tick: the table memory is swept one channel a cycle through a one-deep read
// pipeline, then the fastest entry is read. Add reads, then writes. Edit reads,
// then writes, and rescans the table when the fastest channel has to be
// rescanned. Error goes straight back to idle.
// Each result is registered and shows in the cycle after it is formed. Synchronous reset empties
// the table; no clearing pass is needed.

module multichannel_sample_scheduler_unit #(
  parameter int MAX_CHANNELS = mss_pkg::MAX_CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mss_pkg::item_t   item,
  output logic             result_strobe,
  output mss_pkg::result_t result
);

  mss_pkg::cmd_t    cmd;
  mss_pkg::status_t status;

  mss_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mss_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .cmd           (cmd),
    .status        (status),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule

FILE: sim/multichannel_sample_scheduler_unit_tb.sv
`timescale 1ns / 1ps

module multichannel_sample_scheduler_unit_tb;

  localparam int          CHANNELS     = mss_pkg::MAX_CHANNELS_DEF;
  localparam logic [1:0]  MODE_BAD     = 2'd3;
  localparam logic [31:0] NEVER_DUE    = 32'hFFFF_FFFF;
  localparam int          RANDOM_ITEMS = 290;
  localparam int          CYCLE_LIMIT  = 200000;

  class channel_table_sb;
    int               count;
    int               fastest;
    logic [31:0]      period [CHANNELS];
    logic [63:0]      stamp [CHANNELS];
    mss_pkg::result_t owed [$];
    int               errors;

    function new();
      count = 0;
      fastest = 0;
      errors = 0;
      foreach (period[i]) begin
        period[i] = '0;
        stamp[i] = '0;
      end
    endfunction

    function void owe(logic [2:0] kind, int idx, logic [31:0] delay, logic susp,
                      logic ovr, logic lst);
      mss_pkg::result_t r;
      r.kind = kind;
      r.channel_index = 4'(idx);
      r.delay_us = delay;
      r.suspend = susp;
      r.overrun = ovr;
      r.last = lst;
      owed.push_back(r);
    endfunction

    // advance the channel table by one accepted item and queue what it owes
    function void take_item(mss_pkg::item_t it);
      int          i;
      logic [31:0] elapsed;
      logic [31:0] old_fast;
      logic [31:0] delay;
      logic [63:0] due;
      logic [63:0] ahead;
      logic        susp;
      logic        ovr;
      case (it.mode)
        mss_pkg::MODE_TICK: begin
          delay = '0;
          susp = 1'b0;
          ovr = 1'b0;
          for (i = 0; i < count; i++) begin
            elapsed = 32'(it.now_us - stamp[i]);
            if (elapsed >= period[i]) begin
              owe(mss_pkg::KIND_DUE, i, '0, 1'b0, 1'b0, 1'b0);
              stamp[i] = it.now_us;
            end
          end
          if (count == 0 || period[fastest] == NEVER_DUE) begin
            susp = 1'b1;
          end else begin
            due = stamp[fastest] + 64'(period[fastest]);
            if (due > it.now_us) begin
              ahead = due - it.now_us;
              delay = (ahead > 64'h0000_0000_FFFF_FFFF) ? NEVER_DUE : ahead[31:0];
            end else begin
              ovr = 1'b1;
            end
          end
          owe(mss_pkg::KIND_WAKE, 0, delay, susp, ovr, 1'b1);
        end
        mss_pkg::MODE_ADD: begin
          if (count >= CHANNELS) begin
            owe(mss_pkg::KIND_ERR, 0, '0, 1'b0, 1'b0, 1'b1);
          end else begin
            if (count == 0) fastest = 0;
            else if (it.period_us < period[fastest]) fastest = count;
            period[count] = it.period_us;
            stamp[count] = '0;
            owe(mss_pkg::KIND_ADD, count, '0, 1'b0, 1'b0, 1'b1);
            count++;
          end
        end
        mss_pkg::MODE_EDIT: begin
          if (int'(it.channel) >= count) begin
            owe(mss_pkg::KIND_ERR, 0, '0, 1'b0, 1'b0, 1'b1);
          end else begin
            old_fast = period[fastest];
            period[it.channel] = it.period_us;
            if (it.period_us < old_fast) begin
              fastest = it.channel;
            end else if (int'(it.channel) == fastest) begin
              fastest = 0;
              for (i = 1; i < count; i++)
                if (period[i] < period[fastest]) fastest = i;
            end
            owe(mss_pkg::KIND_EDIT, it.channel, '0, 1'b0, 1'b0, 1'b1);
          end
        end
        default: begin
          owe(mss_pkg::KIND_ERR, 0, '0, 1'b0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(mss_pkg::result_t got);
      mss_pkg::result_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: kind %0h channel_index %0h", got.kind, got.channel_index);
        errors++;
      end else begin
        want = owed.pop_front();
        compare("kind", want.kind, got.kind);
        compare("channel_index", want.channel_index, got.channel_index);
        compare("delay_us", want.delay_us, got.delay_us);
        compare("suspend", want.suspend, got.suspend);
        compare("overrun", want.overrun, got.overrun);
        compare("last", want.last, got.last);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  mss_pkg::item_t   item = '0;
  logic             result_strobe;
  mss_pkg::result_t result;
  channel_table_sb  sb;
  int               gap_max = 12;
  int               cycles = 0;
  logic [63:0]      clock_us = '0;

  multichannel_sample_scheduler_unit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_strobe(result_strobe),
    .result(result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_strobe === 1'b1) sb.match_result(result);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("multichannel_sample_scheduler_unit regression: fail");
      $finish;
    end
  end

  task automatic issue(logic [1:0] mode, logic [63:0] now_us, logic [3:0] channel,
                       logic [31:0] period_us);
    mss_pkg::item_t it;
    int             wait_cycles;
    it.mode = mode;
    it.now_us = now_us;
    it.channel = channel;
    it.period_us = period_us;
    wait_cycles = $urandom_range(0, gap_max);
    if (wait_cycles > 0) begin
      start <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    sb.take_item(it);
  endtask

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return NEVER_DUE;
      2:       return $urandom;
      3:       return $urandom_range(1, 5);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  initial begin
    int          n;
    int          pick;
    logic [3:0]  ch;
    logic [63:0] noise;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused channel, bad mode
    issue(mss_pkg::MODE_TICK, 64'd0, 4'd0, 32'd0);
    issue(mss_pkg::MODE_EDIT, 64'd0, 4'hF, 32'd5);
    issue(MODE_BAD, '1, 4'hF, '1);
    // fastest channel never due
    issue(mss_pkg::MODE_ADD, 64'd0, 4'd0, NEVER_DUE);
    issue(mss_pkg::MODE_TICK, 64'd5, 4'd0, 32'd0);
    issue(mss_pkg::MODE_ADD, 64'd0, 4'd0, 32'd100);
    issue(mss_pkg::MODE_TICK, 64'd50, 4'd0, 32'd0);
    issue(mss_pkg::MODE_TICK, 64'd100, 4'd0, 32'd0);
    // zero period: overrun
    issue(mss_pkg::MODE_ADD, 64'd0, 4'd0, 32'd0);
    issue(mss_pkg::MODE_TICK, 64'd100, 4'd0, 32'd0);
    // fastest edited upward forces a rescan
    issue(mss_pkg::MODE_EDIT, 64'd0, 4'd2, NEVER_DUE);
    issue(mss_pkg::MODE_EDIT, 64'd0, 4'd0, 32'd10);
    issue(mss_pkg::MODE_TICK, '1, 4'd0, 32'd0);
    // time going backwards saturates the delay
    issue(mss_pkg::MODE_EDIT, 64'd0, 4'd0, 32'd1);
    issue(mss_pkg::MODE_TICK, 64'h0000_0100_0000_0000, 4'd0, 32'd0);
    issue(mss_pkg::MODE_TICK, 64'd0, 4'd0, 32'd0);
    issue(mss_pkg::MODE_EDIT, 64'd0, 4'd1, NEVER_DUE);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      pick = $urandom_range(0, 99);
      noise = {$urandom, $urandom};
      if (pick < 55) begin
        case ($urandom_range(0, 19))
          0:       clock_us = noise;
          1:       clock_us = clock_us - $urandom_range(0, 500);
          2:       clock_us = clock_us + 64'h1_0000_0000 + $urandom_range(0, 50);
          default: clock_us = clock_us + $urandom_range(0, 300);
        endcase
        issue(mss_pkg::MODE_TICK, clock_us, 4'($urandom), $urandom);
      end else if (pick < 67) begin
        issue(mss_pkg::MODE_ADD, noise, 4'($urandom), pick_period());
      end else if (pick < 95) begin
        if (sb.count > 0 && $urandom_range(0, 4) != 0) ch = 4'($urandom_range(0, sb.count - 1));
        else ch = 4'($urandom_range(0, 15));
        issue(mss_pkg::MODE_EDIT, noise, ch, pick_period());
      end else begin
        issue(MODE_BAD, noise, 4'($urandom), $urandom);
      end
    end

    // make sure the table fills and one add overflows it
    while (sb.count < CHANNELS) issue(mss_pkg::MODE_ADD, 64'd0, 4'd0, pick_period());
    issue(mss_pkg::MODE_ADD, 64'd0, 4'd0, 32'd1);
    issue(mss_pkg::MODE_TICK, clock_us + 64'd1000, 4'd0, 32'd0);
    start <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("multichannel_sample_scheduler_unit regression: pass");
    end else begin
      $display("multichannel_sample_scheduler_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mss_pkg.sv
src/mss_ctrl.sv
src/mss_datapath.sv
src/multichannel_sample_scheduler_unit.sv
sim/multichannel_sample_scheduler_unit_tb.sv
